// ===== design/tcp_syn_header_builder_assert.svh =====
// ----------------------------------------------------------------------------
// tcp_syn_header_builder_assert.svh
// Assertion macros used by the top-level header builder RTL.
// ----------------------------------------------------------------------------
`ifndef TCP_SYN_HEADER_BUILDER_ASSERT_SVH
`define TCP_SYN_HEADER_BUILDER_ASSERT_SVH

// same-cycle implication, sampled on clk, muted in reset
`define TSH_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, sampled on clk, muted in reset
`define TSH_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ===== design/tsh_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tsh_pkg
// Types and constants for the IPv4/TCP SYN header builder.
// ----------------------------------------------------------------------------
package tsh_pkg;

  // register map (index = paddr[4:2])
  localparam int unsigned PADDR_W = 5;
  localparam logic [2:0] REG_SRC_ADDR = 3'd0;
  localparam logic [2:0] REG_DST_ADDR = 3'd1;
  localparam logic [2:0] REG_SRC_PORT = 3'd2;
  localparam logic [2:0] REG_DST_PORT = 3'd3;
  localparam logic [2:0] REG_MODE     = 3'd4;

  // embedding modes (1 and 2 both select the sequence number)
  localparam logic [1:0] MODE_IDENT = 2'd0;
  localparam logic [1:0] MODE_URG   = 2'd3;

  // header layout
  localparam int unsigned NUM_WORDS = 10;
  localparam logic [3:0]  IDX_LAST  = 4'(NUM_WORDS - 1);

  localparam logic [31:0] HDR_W0    = 32'h4500_0028; // ver/ihl, tos, len 40
  localparam logic [15:0] HDR_TTLPR = 16'h4006;      // ttl 64, proto 6
  localparam logic [31:0] HDR_W8    = 32'h5002_0200; // doff 5, SYN, win 512

  // constant parts of the two ones-complement sums
  localparam logic [19:0] IP_SUM_K  = 20'h0852E; // 4500 + 0028 + 4006
  localparam logic [19:0] TCP_SUM_K = 20'h0521C; // 0006 + 0014 + 5002 + 0200

  // configuration registers as seen by the datapath
  typedef struct packed {
    logic [31:0] src_addr;
    logic [31:0] dst_addr;
    logic [15:0] src_port;
    logic [15:0] dst_port;
    logic [1:0]  encode_mode;
  } cfg_t;

  // finished variable header fields, already in wire byte order
  typedef struct packed {
    logic [15:0] ident;
    logic [15:0] sport;
    logic [15:0] seq;
    logic [15:0] urg;
    logic [15:0] ip_chk;
    logic [15:0] tcp_chk;
  } hdr_fields_t;

  // fold a 20-bit ones-complement sum to 16 bits and invert it
  function automatic logic [15:0] fold_invert(input logic [19:0] s);
    logic [16:0] f1;
    logic [16:0] f2;
    f1 = {1'b0, s[15:0]} + {13'd0, s[19:16]};
    f2 = {1'b0, f1[15:0]} + {16'd0, f1[16]};
    return ~f2[15:0];
  endfunction

endpackage

// ===== design/tcp_syn_header_builder.sv =====
`timescale 1ns / 1ps
// A command taken on start passes the select, sum and fold stages and is then loaded
// into the serializer, which sends the header's ten beats with no gaps in a header.
// Headers leave through the single 32-bit result port.
// A new item is taken while the previous header is still being sent.
// Reset (rst, synchronous) clears the config registers to 0 and empties the pipe.
// ----------------------------------------------------------------------------
// tcp_syn_header_builder
// Builds IPv4+TCP SYN headers with both checksums and streams them as words.
// ----------------------------------------------------------------------------
`include "tcp_syn_header_builder_assert.svh"

module tcp_syn_header_builder
  import tsh_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  // config port
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready,
  // command
  input  logic               start,
  output logic               busy,
  input  logic [7:0]         embed_byte,
  input  logic [13:0]        rand_port,
  input  logic [7:0]         rand_ident,
  input  logic [13:0]        rand_seq,
  // result beats
  output logic               word_valid,
  output logic [31:0]        header_word,
  output logic [3:0]         word_index,
  output logic               last_word
);

  cfg_t        cfg;
  logic        pipe_ready;
  logic        hdr_valid;
  logic        ser_ready;
  hdr_fields_t hdr_fields;

  assign busy = !pipe_ready;

  tsh_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  tsh_csum_pipe u_pipe (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .in_valid   (start),
    .in_ready   (pipe_ready),
    .embed_byte (embed_byte),
    .rand_port  (rand_port),
    .rand_ident (rand_ident),
    .rand_seq   (rand_seq),
    .out_valid  (hdr_valid),
    .out_ready  (ser_ready),
    .out_fields (hdr_fields)
  );

  tsh_serializer u_ser (
    .clk         (clk),
    .rst         (rst),
    .cfg         (cfg),
    .in_valid    (hdr_valid),
    .in_ready    (ser_ready),
    .in_fields   (hdr_fields),
    .word_valid  (word_valid),
    .header_word (header_word),
    .word_index  (word_index),
    .last_word   (last_word)
  );

  // beats of one header come back to back in index order
  `TSH_ASSERT_NEXT(a_beat_seq, word_valid && !last_word, word_valid && word_index == $past(word_index) + 4'd1, "header beats not contiguous")
  // first beat carries the fixed version/length word
  `TSH_ASSERT_NOW(a_first_word, word_valid && word_index == 4'd0, header_word == HDR_W0, "bad first header word")
  // a finished header waiting on the serializer must hold off new commands
  `TSH_ASSERT_NOW(a_busy_stall, hdr_valid && !ser_ready && u_pipe.v2 && u_pipe.v1, busy, "busy low with a full pipe")

endmodule

// ===== design/tsh_regs.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tsh_regs
// APB-style register file holding addresses, ports and embedding mode.
// ----------------------------------------------------------------------------
module tsh_regs
  import tsh_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready,
  output cfg_t               cfg
);

  logic       wr_en;
  logic [2:0] reg_idx;

  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite;
  assign reg_idx = paddr[PADDR_W-1:2];

  // register writes; indexes past the map are dropped
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= '0;
    end else if (wr_en) begin
      case (reg_idx)
        REG_SRC_ADDR: cfg.src_addr    <= pwdata;
        REG_DST_ADDR: cfg.dst_addr    <= pwdata;
        REG_SRC_PORT: cfg.src_port    <= pwdata[15:0];
        REG_DST_PORT: cfg.dst_port    <= pwdata[15:0];
        REG_MODE:     cfg.encode_mode <= pwdata[1:0];
        default: ;
      endcase
    end
  end

  // read mux
  always_comb begin
    case (reg_idx)
      REG_SRC_ADDR: prdata = cfg.src_addr;
      REG_DST_ADDR: prdata = cfg.dst_addr;
      REG_SRC_PORT: prdata = {16'd0, cfg.src_port};
      REG_DST_PORT: prdata = {16'd0, cfg.dst_port};
      REG_MODE:     prdata = {30'd0, cfg.encode_mode};
      default:      prdata = '0;
    endcase
  end

endmodule

// ===== design/tsh_csum_pipe.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tsh_csum_pipe
// Three-stage pipeline: field select, checksum sums, fold and invert.
// ----------------------------------------------------------------------------
module tsh_csum_pipe
  import tsh_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  cfg_t        cfg,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  embed_byte,
  input  logic [13:0] rand_port,
  input  logic [7:0]  rand_ident,
  input  logic [13:0] rand_seq,
  output logic        out_valid,
  input  logic        out_ready,
  output hdr_fields_t out_fields
);

  // stage 1: selected fields and address sum
  logic        v1;
  logic [15:0] s1_ident, s1_sport, s1_seq, s1_urg;
  logic [17:0] s1_addr_sum;
  // stage 2: raw sums
  logic        v2;
  logic [15:0] s2_ident, s2_sport, s2_seq, s2_urg;
  logic [19:0] s2_ip_sum, s2_tcp_sum;
  // stage 3: finished fields
  logic        v3;

  logic ready1, ready2, ready3;
  logic [15:0] sel_ident, sel_sport, sel_seq, sel_urg;
  logic [7:0]  seq_byte_lo, seq_byte_hi;

  assign ready3   = !v3 || out_ready;
  assign ready2   = !v2 || ready3;
  assign ready1   = !v1 || ready2;
  assign in_ready = ready1;

  // field selection, byte-swapped as a little-endian host stores them
  always_comb begin
    seq_byte_lo = rand_seq[7:0];
    seq_byte_hi = {2'd0, rand_seq[13:8]};
    sel_urg     = 16'd0;
    if (cfg.encode_mode == MODE_IDENT) begin
      sel_ident = {embed_byte, 8'd0};
    end else begin
      sel_ident = {rand_ident, 8'd0};
    end
    if (cfg.encode_mode == MODE_URG) begin
      sel_urg = {embed_byte, 8'd0};
    end
    if (cfg.encode_mode != MODE_IDENT && cfg.encode_mode != MODE_URG) begin
      sel_seq = {embed_byte, 8'd0};
    end else begin
      sel_seq = {seq_byte_lo, seq_byte_hi};
    end
    if (cfg.src_port == 16'd0) begin
      sel_sport = {rand_port[7:0], 2'd0, rand_port[13:8]};
    end else begin
      sel_sport = cfg.src_port;
    end
  end

  // valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
    end else begin
      if (ready1) v1 <= in_valid;
      if (ready2) v2 <= v1;
      if (ready3) v3 <= v2;
    end
  end

  // stage 1
  always_ff @(posedge clk) begin
    if (in_valid && ready1) begin
      s1_ident    <= sel_ident;
      s1_sport    <= sel_sport;
      s1_seq      <= sel_seq;
      s1_urg      <= sel_urg;
      s1_addr_sum <= {2'd0, cfg.src_addr[31:16]} + {2'd0, cfg.src_addr[15:0]}
                   + {2'd0, cfg.dst_addr[31:16]} + {2'd0, cfg.dst_addr[15:0]};
    end
  end

  // stage 2: IP header sum and TCP pseudo-header sum
  always_ff @(posedge clk) begin
    if (v1 && ready2) begin
      s2_ident   <= s1_ident;
      s2_sport   <= s1_sport;
      s2_seq     <= s1_seq;
      s2_urg     <= s1_urg;
      s2_ip_sum  <= IP_SUM_K + {2'd0, s1_addr_sum} + {4'd0, s1_ident};
      s2_tcp_sum <= TCP_SUM_K + {2'd0, s1_addr_sum} + {4'd0, s1_sport}
                  + {4'd0, cfg.dst_port} + {4'd0, s1_seq} + {4'd0, s1_urg};
    end
  end

  // stage 3: fold end-around carries and invert
  always_ff @(posedge clk) begin
    if (v2 && ready3) begin
      out_fields.ident   <= s2_ident;
      out_fields.sport   <= s2_sport;
      out_fields.seq     <= s2_seq;
      out_fields.urg     <= s2_urg;
      out_fields.ip_chk  <= fold_invert(s2_ip_sum);
      out_fields.tcp_chk <= fold_invert(s2_tcp_sum);
    end
  end

  assign out_valid = v3;

endmodule

// ===== design/tsh_serializer.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tsh_serializer
// Holds one finished header and sends it as ten 32-bit beats.
// ----------------------------------------------------------------------------
module tsh_serializer
  import tsh_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  cfg_t        cfg,
  input  logic        in_valid,
  output logic        in_ready,
  input  hdr_fields_t in_fields,
  output logic        word_valid,
  output logic [31:0] header_word,
  output logic [3:0]  word_index,
  output logic        last_word
);

  logic        active;
  logic [3:0]  idx;
  hdr_fields_t hdr;
  logic        load;

  assign in_ready = !active || (idx == IDX_LAST);
  assign load     = in_valid && in_ready;

  // beat counter
  always_ff @(posedge clk) begin
    if (rst) begin
      active <= 1'b0;
      idx    <= '0;
    end else if (load) begin
      active <= 1'b1;
      idx    <= '0;
    end else if (active) begin
      if (idx == IDX_LAST) begin
        active <= 1'b0;
      end else begin
        idx <= idx + 4'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) hdr <= in_fields;
  end

  // word select
  always_comb begin
    case (idx)
      4'd0:    header_word = HDR_W0;
      4'd1:    header_word = {hdr.ident, 16'd0};
      4'd2:    header_word = {HDR_TTLPR, hdr.ip_chk};
      4'd3:    header_word = cfg.src_addr;
      4'd4:    header_word = cfg.dst_addr;
      4'd5:    header_word = {hdr.sport, cfg.dst_port};
      4'd6:    header_word = {hdr.seq, 16'd0};
      4'd7:    header_word = 32'd0;
      4'd8:    header_word = HDR_W8;
      4'd9:    header_word = {hdr.tcp_chk, hdr.urg};
      default: header_word = 32'd0;
    endcase
  end

  assign word_valid = active;
  assign word_index = idx;
  assign last_word  = active && (idx == IDX_LAST);

endmodule

// ===== tb/tb_tcp_syn_header_builder.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_tcp_syn_header_builder
// Drives header build commands and APB register writes into the SYN header
// builder, predicts every 32-bit header beat (including both ones-complement
// checksums) and compares the beats field by field in order of arrival.
// ----------------------------------------------------------------------------
module tb_tcp_syn_header_builder;
  import tsh_pkg::*;

  // one expected header beat
  typedef struct {
    logic [31:0] word;
    logic [3:0]  idx;
    logic        last;
  } hdr_beat_t;

  // expected header beats and the register shadow they are built from
  class syn_header_board;
    cfg_t      regs;
    hdr_beat_t beats_due[$];
    int        errors;

    function new();
      regs   = '0;
      errors = 0;
    endfunction

    // register shadow; unmapped indexes are dropped, values masked to width
    function void set_reg(logic [2:0] idx, logic [31:0] d);
      case (idx)
        REG_SRC_ADDR: regs.src_addr = d;
        REG_DST_ADDR: regs.dst_addr = d;
        REG_SRC_PORT: regs.src_port = d[15:0];
        REG_DST_PORT: regs.dst_port = d[15:0];
        REG_MODE:     regs.encode_mode = d[1:0];
        default: ;
      endcase
    endfunction

    // fold to 16 bits and invert
    function logic [15:0] ones_check(logic [31:0] s);
      while (s[31:16] != 0) s = {16'd0, s[15:0]} + {16'd0, s[31:16]};
      return ~s[15:0];
    endfunction

    // build the whole header for one accepted command
    function void note_item(logic [7:0] data_byte, logic [13:0] rport,
                            logic [7:0] rident, logic [13:0] rseq);
      logic [15:0] ident;
      logic [15:0] urg;
      logic [15:0] sport;
      logic [15:0] p16;
      logic [31:0] seq;
      logic [31:0] acc;
      logic [31:0] w [10];
      hdr_beat_t   b;
      int          k;
      ident = {8'd0, rident};
      seq   = {18'd0, rseq};
      urg   = '0;
      if (regs.encode_mode == MODE_IDENT) ident = {8'd0, data_byte};
      else if (regs.encode_mode == MODE_URG) urg = {8'd0, data_byte};
      else seq = {24'd0, data_byte};
      // random port goes out without htons
      p16   = {2'b00, rport};
      sport = (regs.src_port == 16'd0) ? {p16[7:0], p16[15:8]} : regs.src_port;

      w[0] = 32'h4500_0028;
      w[1] = {ident[7:0], ident[15:8], 16'h0000};
      w[2] = 32'h4006_0000;
      w[3] = regs.src_addr;
      w[4] = regs.dst_addr;
      w[5] = {sport, regs.dst_port};
      w[6] = {seq[7:0], seq[15:8], seq[23:16], seq[31:24]};
      w[7] = 32'h0;
      w[8] = 32'h5002_0200;
      w[9] = {16'h0000, urg[7:0], urg[15:8]};

      // IP header checksum over words 0..4
      acc = 0;
      for (k = 0; k < 5; k++) acc += {16'd0, w[k][31:16]} + {16'd0, w[k][15:0]};
      w[2][15:0] = ones_check(acc);

      // TCP checksum: pseudo-header, then TCP header with check zero
      acc = {16'd0, regs.src_addr[31:16]} + {16'd0, regs.src_addr[15:0]} +
            {16'd0, regs.dst_addr[31:16]} + {16'd0, regs.dst_addr[15:0]} +
            32'h0006 + 32'h0014;
      for (k = 5; k < 10; k++) acc += {16'd0, w[k][31:16]} + {16'd0, w[k][15:0]};
      w[9][31:16] = ones_check(acc);

      for (k = 0; k < 10; k++) begin
        b.word = w[k];
        b.idx  = 4'(k);
        b.last = (k == 9);
        beats_due.push_back(b);
      end
    endfunction

    function void check_word(logic [31:0] word, logic [3:0] idx, logic last);
      hdr_beat_t b;
      if (beats_due.size() == 0) begin
        errors++;
        $display("%0t: unexpected beat word=%h index=%0d last=%b", $time, word, idx, last);
        return;
      end
      b = beats_due.pop_front();
      if (word !== b.word) begin
        errors++;
        $display("%0t: header_word exp %h got %h", $time, b.word, word);
      end
      if (idx !== b.idx) begin
        errors++;
        $display("%0t: word_index exp %0d got %0d", $time, b.idx, idx);
      end
      if (last !== b.last) begin
        errors++;
        $display("%0t: last_word exp %b got %b", $time, b.last, last);
      end
    endfunction

    function int pending();
      return beats_due.size();
    endfunction
  endclass

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               psel = 1'b0;
  logic               penable = 1'b0;
  logic               pwrite = 1'b0;
  logic [PADDR_W-1:0] paddr = '0;
  logic [31:0]        pwdata = '0;
  logic [31:0]        prdata;
  logic               pready;
  logic               start = 1'b0;
  logic               busy;
  logic [7:0]         embed_byte = '0;
  logic [13:0]        rand_port = '0;
  logic [7:0]         rand_ident = '0;
  logic [13:0]        rand_seq = '0;
  logic               word_valid;
  logic [31:0]        header_word;
  logic [3:0]         word_index;
  logic               last_word;

  syn_header_board board = new();

  tcp_syn_header_builder uut (
    .clk         (clk),
    .rst         (rst),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready),
    .start       (start),
    .busy        (busy),
    .embed_byte  (embed_byte),
    .rand_port   (rand_port),
    .rand_ident  (rand_ident),
    .rand_seq    (rand_seq),
    .word_valid  (word_valid),
    .header_word (header_word),
    .word_index  (word_index),
    .last_word   (last_word)
  );

  // 4 ns clock
  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // check every beat on the result port
  always @(posedge clk) begin
    if (!rst && word_valid) board.check_word(header_word, word_index, last_word);
  end

  // APB write; the register takes the data at the access edge, then the bus goes idle
  task automatic write_reg(input logic [2:0] idx, input logic [31:0] d);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= d;
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    board.set_reg(idx, d);
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(negedge clk);
  endtask

  // present one command and hold it until taken; start stays high afterwards
  task automatic send_item(input logic [7:0] b, input logic [13:0] p,
                           input logic [7:0] i, input logic [13:0] s);
    start      <= 1'b1;
    embed_byte <= b;
    rand_port  <= p;
    rand_ident <= i;
    rand_seq   <= s;
    @(posedge clk);
    while (busy) @(posedge clk);
    board.note_item(b, p, i, s);
    @(negedge clk);
  endtask

  // sender gap with junk on the data fields
  task automatic sender_gap(input int n);
    start      <= 1'b0;
    embed_byte <= 8'($urandom);
    rand_port  <= 14'($urandom);
    rand_ident <= 8'($urandom);
    rand_seq   <= 14'($urandom);
    repeat (n) @(negedge clk);
  endtask

  // wait until every header has come out, then let the bench idle
  task automatic wait_drained();
    start <= 1'b0;
    while (board.pending() > 0) @(negedge clk);
    repeat (6) @(negedge clk);
  endtask

  function automatic logic [31:0] pick_addr();
    case ($urandom_range(0, 3))
      0: return 32'h0;
      1: return 32'hffff_ffff;
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [31:0] pick_port();
    case ($urandom_range(0, 5))
      0, 1, 2: return 32'h0;
      3: return 32'h0000_ffff;
      default: return $urandom;
    endcase
  endfunction

  task automatic send_random_item();
    logic [13:0] p;
    logic [7:0]  i;
    logic [13:0] s;
    // mostly in the documented ranges, sometimes anything the width allows
    p = ($urandom_range(0, 5) == 0) ? 14'($urandom) : 14'($urandom_range(1, 10000));
    i = ($urandom_range(0, 5) == 0) ? 8'($urandom) : 8'($urandom_range(0, 254));
    s = ($urandom_range(0, 5) == 0) ? 14'($urandom) : 14'($urandom_range(1, 10000));
    send_item(8'($urandom), p, i, s);
  endtask

  // time limit
  initial begin
    #2_000_000;
    $display("Mismatches found");
    $finish;
  end

  initial begin
    int idle_odds;
    int ph;
    int n;

    repeat (9) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // reset config: ident mode, random port, zero addresses; field extremes
    send_item(8'h00, 14'h0000, 8'h00, 14'h0000);
    send_item(8'hff, 14'h3fff, 8'hff, 14'h3fff);
    send_item(8'ha5, 14'd1, 8'd254, 14'd10000);
    send_item(8'h5a, 14'd10000, 8'h00, 14'd1);

    // sequence mode (1), all-ones addresses and ports
    wait_drained();
    write_reg(REG_SRC_ADDR, 32'hffff_ffff);
    write_reg(REG_DST_ADDR, 32'hffff_ffff);
    write_reg(REG_SRC_PORT, 32'hffff_ffff);
    write_reg(REG_DST_PORT, 32'hffff_ffff);
    write_reg(REG_MODE, 32'h0000_0001);
    send_item(8'hff, 14'h3fff, 8'hff, 14'h3fff);
    send_item(8'h00, 14'h0000, 8'h00, 14'h0000);
    send_item(8'h81, 14'h2aaa, 8'h55, 14'h1555);

    // sequence mode (2), fixed source port 1, destination port 0
    wait_drained();
    write_reg(REG_SRC_PORT, 32'h0000_0001);
    write_reg(REG_DST_PORT, 32'h0000_0000);
    write_reg(REG_MODE, 32'h0000_0002);
    send_item(8'h7e, 14'h1555, 8'haa, 14'h2aaa);
    send_item(8'hff, 14'd1, 8'd0, 14'd10000);
    send_item(8'h01, 14'h3fff, 8'hff, 14'h0000);

    // urgent mode; for the first command both sums fold to all ones, so both checksums are zero
    wait_drained();
    write_reg(REG_SRC_ADDR, 32'h7ad1_0000);
    write_reg(REG_DST_ADDR, 32'h0000_0000);
    write_reg(REG_SRC_PORT, 32'h0000_1234);
    write_reg(REG_DST_PORT, 32'h0000_20de);
    write_reg(REG_MODE, 32'h0000_0003);
    send_item(8'h00, 14'h0123, 8'h00, 14'h0000);
    send_item(8'hff, 14'h3fff, 8'hff, 14'h3fff);

    // unmapped indexes must not disturb anything; oversized data is masked
    wait_drained();
    write_reg(3'd5, 32'hdead_beef);
    write_reg(3'd6, 32'hffff_ffff);
    write_reg(3'd7, 32'h1234_5678);
    write_reg(REG_SRC_PORT, 32'hffff_0000);
    write_reg(REG_MODE, 32'hffff_fffc);
    send_item(8'h3c, 14'd4321, 8'd17, 14'd9999);
    send_item(8'hc3, 14'h3fff, 8'd200, 14'd1);

    // random phases, each with a fresh register setting
    for (ph = 0; ph < 10; ph++) begin
      wait_drained();
      write_reg(REG_SRC_ADDR, pick_addr());
      write_reg(REG_DST_ADDR, pick_addr());
      write_reg(REG_SRC_PORT, pick_port());
      write_reg(REG_DST_PORT, pick_port());
      write_reg(REG_MODE, $urandom);
      if ($urandom_range(0, 3) == 0) write_reg(3'($urandom_range(5, 7)), $urandom);
      // no gaps in the last phase, some phases back to back, some sparse
      idle_odds = (ph == 9) ? 0 : $urandom_range(0, 2);
      for (n = 0; n < 25; n++) begin
        if (idle_odds == 1 && $urandom_range(0, 7) == 0) sender_gap($urandom_range(1, 16));
        if (idle_odds == 2 && $urandom_range(0, 1) == 0) sender_gap($urandom_range(1, 16));
        // hold off once mid-phase until the pipe is empty
        if (ph == 4 && n == 12) wait_drained();
        send_random_item();
      end
    end

    wait_drained();
    if (board.errors == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
